### rtl/pas_pkg.sv
// shared types, widths, constants and stage functions for the particle step pipeline
// no dependencies
package pas_pkg;

  localparam int POS_W     = 24;
  localparam int T_W       = 16;
  localparam int GAIN_W    = 17;
  localparam int DIFF_W    = POS_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int KT_W      = T_W + GAIN_W;
  localparam int NUM_W     = DIFF_W + KT_W;
  localparam int QUOT_BITS = 26;
  localparam int CMP_W     = NUM_W + QUOT_BITS;
  localparam int SQRT_W    = 32;
  localparam int SQRT_STEPS = SQRT_W / 2;
  localparam int SUM_W     = POS_W + QUOT_BITS + 2;
  localparam int MUL_W     = POS_W + T_W + 1;
  localparam int SPIN_W    = 32;
  localparam int LATENCY   = SQRT_STEPS + QUOT_BITS + 7;

  localparam logic [GAIN_W-1:0] GAIN    = 17'd100000;
  localparam logic [T_W:0]      DAMP    = 17'd64881;
  localparam logic [T_W-1:0]    T_RESET = 16'd1092;

  localparam logic [1:0] REG_AX    = 2'd0;
  localparam logic [1:0] REG_AY    = 2'd1;
  localparam logic [1:0] REG_REPEL = 2'd2;
  localparam logic [1:0] REG_TSTEP = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  vx;
    logic signed [POS_W-1:0]  vy;
    logic [SPIN_W-1:0]        spin;
    logic [T_W-1:0]           t;
    logic                     repel;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [KT_W-1:0]          kt;
    logic                     negx;
    logic                     negy;
    logic [SQ_W-1:0]          sqx;
    logic [SQ_W-1:0]          sqy;
    logic [NUM_W-1:0]         remx;
    logic [NUM_W-1:0]         remy;
    logic [SQ_W-1:0]          s;
    logic                     zero;
    logic                     small_dist;
    logic [SQRT_W-1:0]        sx;
    logic [SQRT_W-1:0]        sr;
    logic [SQ_W-1:0]          den;
    logic [QUOT_BITS-1:0]     qx;
    logic [QUOT_BITS-1:0]     qy;
    logic signed [MUL_W-1:0]  mtx;
    logic signed [MUL_W-1:0]  mty;
    logic signed [MUL_W-1:0]  mdx;
    logic signed [MUL_W-1:0]  mdy;
  } rec_t;

  // one digit of the integer square root, k from 0
  function automatic rec_t sqrt_step(input rec_t a, input int k);
    rec_t o;
    logic [SQRT_W:0] b;
    logic [SQRT_W:0] trial;
    o = a;
    b = (SQRT_W + 1)'(1) << (SQRT_W - 2 - 2 * k);
    trial = {1'b0, a.sr} + b;
    if ({1'b0, a.sx} >= trial) begin
      o.sx = a.sx - trial[SQRT_W-1:0];
      o.sr = (a.sr >> 1) + b[SQRT_W-1:0];
    end else begin
      o.sr = a.sr >> 1;
    end
    return o;
  endfunction

  // one quotient bit of both restoring dividers
  function automatic rec_t div_step(input rec_t a, input int i);
    rec_t o;
    logic [CMP_W-1:0] dsh;
    o = a;
    dsh = CMP_W'(a.den) << i;
    if (CMP_W'(a.remx) >= dsh) begin
      o.remx = a.remx - dsh[NUM_W-1:0];
      o.qx[i] = 1'b1;
    end
    if (CMP_W'(a.remy) >= dsh) begin
      o.remy = a.remy - dsh[NUM_W-1:0];
      o.qy[i] = 1'b1;
    end
    return o;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = signed'(SUM_W'({1'b0, {(POS_W-1){1'b1}}}));
    lo = -hi - SUM_W'(1);
    if (v > hi) return hi[POS_W-1:0];
    else if (v < lo) return lo[POS_W-1:0];
    else return v[POS_W-1:0];
  endfunction

endpackage

### rtl/particle_attractor_step.sv
// the done strobe marks the result of a start once it has passed every stage listed below
// throughput: one item per cycle, busy is always low and the receiver cannot stall
// stages: difference, products, distance sum, 16 square root digits, divisor select,
//   26 quotient bits for both axes, velocity update, multiplies, output register
// reset: rst synchronous, clears valid bits and loads register reset values
// depends on pas_pkg
module particle_attractor_step
  import pas_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [POS_W-1:0]        cfg_data,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] vel_x,
  input  logic signed [POS_W-1:0] vel_y,
  input  logic signed [SPIN_W-1:0] spin_angle,
  output logic                    done,
  output logic signed [POS_W-1:0] new_pos_x,
  output logic signed [POS_W-1:0] new_pos_y,
  output logic signed [POS_W-1:0] new_vel_x,
  output logic signed [POS_W-1:0] new_vel_y,
  output logic signed [SPIN_W-1:0] new_spin_angle
);

  logic signed [POS_W-1:0] attractor_x;
  logic signed [POS_W-1:0] attractor_y;
  logic                    repel_mode;
  logic [T_W-1:0]          time_step;

  rec_t s1, s2, s3, sd, sv, sm;
  rec_t sq_p [SQRT_STEPS];
  rec_t dv_p [QUOT_BITS];
  logic v1, v2, v3, vd, vv, vm;
  logic [SQRT_STEPS-1:0] vsq;
  logic [QUOT_BITS-1:0]  vdv;

  rec_t s1_next, s2_next, s3_next, sd_next, sv_next, sm_next;
  logic [DIFF_W-1:0] magx, magy;
  logic [SQ_W-1:0]   ssum;
  logic signed [QUOT_BITS:0] dvx, dvy;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attractor_x <= '0;
      attractor_y <= '0;
      repel_mode  <= 1'b0;
      time_step   <= T_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AX:    attractor_x <= cfg_data;
        REG_AY:    attractor_y <= cfg_data;
        REG_REPEL: repel_mode  <= cfg_data[0];
        REG_TSTEP: time_step   <= cfg_data[T_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    s1_next = '0;
    s1_next.px = pos_x;
    s1_next.py = pos_y;
    s1_next.vx = vel_x;
    s1_next.vy = vel_y;
    s1_next.spin = spin_angle + SPIN_W'({time_step, 1'b0});
    s1_next.t = time_step;
    s1_next.repel = repel_mode;
    s1_next.dx = {attractor_x[POS_W-1], attractor_x} - {pos_x[POS_W-1], pos_x};
    s1_next.dy = {attractor_y[POS_W-1], attractor_y} - {pos_y[POS_W-1], pos_y};
    s1_next.kt = KT_W'(GAIN) * KT_W'(time_step);
  end

  always_comb begin
    s2_next = s1;
    magx = s1.dx[DIFF_W-1] ? DIFF_W'(-s1.dx) : DIFF_W'(s1.dx);
    magy = s1.dy[DIFF_W-1] ? DIFF_W'(-s1.dy) : DIFF_W'(s1.dy);
    s2_next.negx = s1.dx[DIFF_W-1] ^ s1.repel;
    s2_next.negy = s1.dy[DIFF_W-1] ^ s1.repel;
    s2_next.sqx = magx * magx;
    s2_next.sqy = magy * magy;
    s2_next.remx = magx * s1.kt;
    s2_next.remy = magy * s1.kt;
  end

  always_comb begin
    s3_next = s2;
    ssum = s2.sqx + s2.sqy;
    s3_next.s = ssum;
    s3_next.zero = (ssum == '0);
    s3_next.small_dist = (ssum < SQ_W'(65536));
    // below one pixel the divisor is sqrt(s) in the same scale as s
    s3_next.sx = {ssum[15:0], 16'd0};
    s3_next.sr = '0;
  end

  always_comb begin
    sd_next = sq_p[SQRT_STEPS-1];
    sd_next.den = sd_next.small_dist ? SQ_W'(sd_next.sr) : sd_next.s;
    sd_next.qx = '0;
    sd_next.qy = '0;
  end

  always_comb begin
    sv_next = dv_p[QUOT_BITS-1];
    dvx = sv_next.negx ? -signed'({1'b0, sv_next.qx}) : signed'({1'b0, sv_next.qx});
    dvy = sv_next.negy ? -signed'({1'b0, sv_next.qy}) : signed'({1'b0, sv_next.qy});
    if (sv_next.zero) begin
      dvx = '0;
      dvy = '0;
    end
    sv_next.vx = sat_pos(SUM_W'(sv_next.vx) + SUM_W'(dvx));
    sv_next.vy = sat_pos(SUM_W'(sv_next.vy) + SUM_W'(dvy));
  end

  always_comb begin
    sm_next = sv;
    sm_next.mtx = sv.vx * signed'({1'b0, sv.t});
    sm_next.mty = sv.vy * signed'({1'b0, sv.t});
    sm_next.mdx = sv.vx * signed'(DAMP);
    sm_next.mdy = sv.vy * signed'(DAMP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      vsq  <= '0;
      vd   <= 1'b0;
      vdv  <= '0;
      vv   <= 1'b0;
      vm   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      vsq  <= {vsq[SQRT_STEPS-2:0], v3};
      vd   <= vsq[SQRT_STEPS-1];
      vdv  <= {vdv[QUOT_BITS-2:0], vd};
      vv   <= vdv[QUOT_BITS-1];
      vm   <= vv;
      done <= vm;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
    s2 <= s2_next;
    s3 <= s3_next;
    sq_p[0] <= sqrt_step(s3, 0);
    for (int k = 1; k < SQRT_STEPS; k++) begin
      sq_p[k] <= sqrt_step(sq_p[k-1], k);
    end
    sd <= sd_next;
    dv_p[0] <= div_step(sd, QUOT_BITS - 1);
    for (int k = 1; k < QUOT_BITS; k++) begin
      dv_p[k] <= div_step(dv_p[k-1], QUOT_BITS - 1 - k);
    end
    sv <= sv_next;
    sm <= sm_next;
    // floor of the Q16 products is an arithmetic shift
    new_pos_x <= sat_pos(SUM_W'(sm.px) + SUM_W'(sm.mtx >>> 16));
    new_pos_y <= sat_pos(SUM_W'(sm.py) + SUM_W'(sm.mty >>> 16));
    new_vel_x <= sat_pos(SUM_W'(sm.mdx >>> 16));
    new_vel_y <= sat_pos(SUM_W'(sm.mdy >>> 16));
    new_spin_angle <= sm.spin;
  end

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("done without a matching start");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (vdv[QUOT_BITS-1] && !dv_p[QUOT_BITS-1].zero) |->
      (dv_p[QUOT_BITS-1].remx < dv_p[QUOT_BITS-1].den &&
       dv_p[QUOT_BITS-1].remy < dv_p[QUOT_BITS-1].den))
    else $error("quotient overflowed its bit count");

  a_damp_x: assert property (@(posedge clk) disable iff (rst)
    done |-> new_vel_x != {1'b1, {(POS_W-1){1'b0}}})
    else $error("damped x velocity hit the negative limit");

  a_damp_y: assert property (@(posedge clk) disable iff (rst)
    done |-> new_vel_y != {1'b1, {(POS_W-1){1'b0}}})
    else $error("damped y velocity hit the negative limit");
`endif

endmodule
